// ----- hw/rtl/sdt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sdt_pkg;

    // Default geometry and crossing precision
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_FRAC_BITS  = 16;

    // Fixed field widths of the beats and the configuration data
    localparam int IDX_W  = 12;
    localparam int DIST_W = 13;
    localparam int CFG_W  = 7;

    // Command codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] pixel_index;
        logic             is_source;
    } cmd_t;

    typedef struct packed {
        logic [DIST_W-1:0] squared_distance;
        logic              is_finite;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RD_WAIT,
        ST_RESP,
        ST_LINE,
        ST_B_RD,
        ST_B_CHK,
        ST_B_MUL,
        ST_B_NUM,
        ST_B_DIV,
        ST_B_POP,
        ST_S_INIT,
        ST_S_LD,
        ST_S_RD,
        ST_S_CHK,
        ST_S_WR
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sdt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sdt_div #(
    parameter int DVD_W = 30,
    parameter int DVS_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CW = $clog2(DVD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   rem_sh;
    logic             ge;
    logic [DVS_W-1:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DVD_W-1]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        rem_next = ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DVD_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/squared_euclidean_distance_transform.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Exact squared Euclidean distance transform over a binary mask of up to
// MAX_WIDTH x MAX_HEIGHT pixels. Send beats on cmd: a mask write (op 0)
// stores is_source at the row-major pixel_index, a run (op 1) transforms
// the in-use image and answers with is_finite set when any source was
// found, a read (op 2) answers with the squared distance of one pixel and
// its finite flag. Writes give no rsp beat; writes beyond width*height are
// dropped and reads there answer not finite. After reset the block sweeps
// its mask and distance memories and holds cmd_ready low meanwhile. A run
// walks every column and then every row through a lower envelope of
// parabolas; each parabola crossing goes through one shared bit-serial
// divider. Program image_width and image_height only while the block is
// idle.
module squared_euclidean_distance_transform #(
    parameter int MAX_WIDTH  = sdt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sdt_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = sdt_pkg::DEF_FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_addr,
    input  logic [sdt_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  sdt_pkg::cmd_t             cmd,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output sdt_pkg::rsp_t             rsp
);

    import sdt_pkg::*;

    // Geometry
    localparam int LINE = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int PW   = $clog2(LINE);           // position within a line
    localparam int LW   = $clog2(LINE + 1);       // line length / counters
    localparam int PIX  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW   = $clog2(PIX);
    localparam int TW   = 2 * LW;
    localparam int CMPW = (TW > IDX_W) ? TW : IDX_W;
    // Distance and crossing widths
    localparam int DMAX = (MAX_WIDTH - 1) * (MAX_WIDTH - 1)
                        + (MAX_HEIGHT - 1) * (MAX_HEIGHT - 1);
    localparam int DW   = $clog2(DMAX + 1);
    localparam int FW   = DW + 1;                 // value plus infinite mark
    localparam int PRW  = 2 * PW + 1;
    localparam int NW   = ((DW > PRW) ? DW : PRW) + 2;
    localparam int MW   = NW - 1;
    localparam int QW   = MW + FRAC_BITS;
    localparam int SW   = QW + 1;

    localparam logic [FW-1:0] INF_MARK = {1'b1, {DW{1'b0}}};

    function automatic logic [LW-1:0] sat(input logic [CFG_W-1:0] v, input int hi);
        logic [LW-1:0] r;
        if (v == '0)
            r = LW'(1);
        else if (int'(v) > hi)
            r = LW'(hi);
        else
            r = LW'(v);
        return r;
    endfunction

    // Control state
    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_reg;
    logic [LW-1:0]   width_reg, height_reg;
    logic            rsp_valid_reg;
    logic            rsp_load;

    // Datapath registers
    cmd_t            cmd_q_reg;
    logic [TW-1:0]   total_reg;
    logic            row_pass_reg, in_scan_reg, any_reg, neg_reg;
    logic [LW-1:0]   line_reg, q_reg, cnt_reg, j_reg;
    logic [AW-1:0]   base_reg, addr_reg;
    logic [PW-1:0]   top_v_reg;
    logic [DW-1:0]   top_f_reg, qf_reg;
    logic signed [SW-1:0] top_z_reg;
    logic [PRW-1:0]  prod_reg;
    logic [DIST_W-1:0] res_dist_reg;
    logic            res_fin_reg;
    rsp_t            rsp_reg;

    // Memories and their read registers
    logic            mask_mem [PIX];
    logic [FW-1:0]   col_mem  [PIX];
    logic [FW-1:0]   dist_mem [PIX];
    logic [PW-1:0]   env_pos_mem [LINE];
    logic [DW-1:0]   env_val_mem [LINE];
    logic [SW-1:0]   env_brk_mem [LINE];
    logic            mask_q;
    logic [FW-1:0]   col_q, dist_q;
    logic [PW-1:0]   env_pos_q;
    logic [DW-1:0]   env_val_q;
    logic [SW-1:0]   env_brk_q;

    // Combinational datapath
    logic [LW-1:0]   line_n, line_total, jn;
    logic            q_last, line_last, in_range;
    logic [AW-1:0]   stride, base_step;
    logic [FW-1:0]   f_line, wr_val;
    logic            f_inf;
    logic [PW-1:0]   xpos, diff, off, mul_a;
    logic [PW:0]     sum, mul_b;
    logic [NW-1:0]   num;
    logic [MW-1:0]   mag;
    logic [QW-1:0]   quo;
    logic            div_done, div_start;
    logic signed [SW-1:0] s_val, x_fix;
    logic            pop, advance;

    // Memory controls
    logic            mask_we, mask_wd, line_re, col_we, dist_we, dist_re;
    logic [AW-1:0]   mask_wa, dist_wa;
    logic [FW-1:0]   dist_wd;
    logic            env_we, env_re, push;
    logic [PW-1:0]   env_ra;
    logic [DW-1:0]   push_f;

    always_comb
    begin
        line_n     = row_pass_reg ? width_reg : height_reg;
        line_total = row_pass_reg ? height_reg : width_reg;
        q_last     = q_reg == LW'(line_n - LW'(1));
        line_last  = line_reg == LW'(line_total - LW'(1));
        stride     = row_pass_reg ? AW'(1) : AW'(width_reg);
        base_step  = row_pass_reg ? AW'(width_reg) : AW'(1);
        in_range   = CMPW'(cmd_q_reg.pixel_index) < CMPW'(total_reg);
        jn         = j_reg + LW'(1);

        // Line source: the mask in the column pass, column results in the row pass
        f_line = row_pass_reg ? col_q : (mask_q ? '0 : INF_MARK);
        f_inf  = f_line[FW-1];

        xpos  = q_reg[PW-1:0];
        diff  = xpos - top_v_reg;
        sum   = {1'b0, xpos} + {1'b0, top_v_reg};
        off   = (xpos > top_v_reg) ? (xpos - top_v_reg) : (top_v_reg - xpos);
        mul_a = in_scan_reg ? off : diff;
        mul_b = in_scan_reg ? {1'b0, off} : sum;

        // Crossing numerator f[q] - f[p] + (q-p)(q+p)
        num = NW'(qf_reg) + NW'(prod_reg) - NW'(top_f_reg);
        mag = num[NW-1] ? MW'(-num) : num[MW-1:0];

        s_val   = neg_reg ? -$signed(SW'(quo)) : $signed(SW'(quo));
        pop     = (cnt_reg > LW'(1)) && (s_val <= top_z_reg);
        x_fix   = $signed(SW'({xpos, {FRAC_BITS{1'b0}}}));
        advance = (jn < cnt_reg) && ($signed(env_brk_q) < x_fix);

        wr_val = (cnt_reg == '0) ? INF_MARK
                                 : {1'b0, DW'(DW'(prod_reg) + top_f_reg)};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (clr_reg == AW'(PIX - 1)) state_next = ST_IDLE;
            ST_IDLE:    if (cmd_valid) state_next = ST_EXEC;
            ST_EXEC:
            begin
                case (cmd_q_reg.op)
                    OP_RUN:  state_next = ST_LINE;
                    OP_READ: state_next = ST_RD_WAIT;
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_RD_WAIT: state_next = ST_RESP;
            ST_RESP:    if (rsp_load) state_next = ST_IDLE;
            ST_LINE:    state_next = ST_B_RD;
            ST_B_RD:    state_next = ST_B_CHK;
            ST_B_CHK:
            begin
                if (f_inf || cnt_reg == '0)
                    state_next = q_last ? ST_S_INIT : ST_B_RD;
                else
                    state_next = ST_B_MUL;
            end
            ST_B_MUL:   state_next = ST_B_NUM;
            ST_B_NUM:   state_next = ST_B_DIV;
            ST_B_DIV:
            begin
                if (div_done)
                begin
                    if (pop)
                        state_next = ST_B_POP;
                    else
                        state_next = q_last ? ST_S_INIT : ST_B_RD;
                end
            end
            ST_B_POP:   state_next = ST_B_MUL;
            ST_S_INIT:  state_next = ST_S_LD;
            ST_S_LD:    state_next = ST_S_RD;
            ST_S_RD:    state_next = ST_S_CHK;
            ST_S_CHK:   state_next = advance ? ST_S_RD : ST_S_WR;
            ST_S_WR:
            begin
                if (!q_last)
                    state_next = ST_S_CHK;
                else if (!line_last || !row_pass_reg)
                    state_next = ST_LINE;
                else
                    state_next = ST_RESP;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Control outputs and memory strobes
    always_comb
    begin
        cmd_ready = state_reg == ST_IDLE;
        rsp_load  = (state_reg == ST_RESP) && (!rsp_valid_reg || rsp_ready);
        mask_we   = 1'b0;
        mask_wa   = addr_reg;
        mask_wd   = 1'b0;
        line_re   = 1'b0;
        col_we    = 1'b0;
        dist_we   = 1'b0;
        dist_wa   = addr_reg;
        dist_wd   = wr_val;
        dist_re   = 1'b0;
        env_re    = 1'b0;
        env_ra    = '0;
        push      = 1'b0;
        push_f    = qf_reg;
        div_start = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mask_we = 1'b1;
                mask_wa = clr_reg;
                dist_we = 1'b1;
                dist_wa = clr_reg;
                dist_wd = INF_MARK;
            end
            ST_EXEC:
            begin
                dist_re = cmd_q_reg.op == OP_READ;
                mask_we = (cmd_q_reg.op == OP_WRITE) && in_range;
                mask_wa = AW'(cmd_q_reg.pixel_index);
                mask_wd = cmd_q_reg.is_source;
            end
            ST_B_RD:  line_re = 1'b1;
            ST_B_CHK:
            begin
                push   = !f_inf && (cnt_reg == '0);
                push_f = f_line[DW-1:0];
            end
            ST_B_NUM: div_start = 1'b1;
            ST_B_DIV:
            begin
                push   = div_done && !pop;
                env_re = div_done && pop;
                env_ra = PW'(cnt_reg - LW'(2));
            end
            ST_S_INIT: env_re = 1'b1;
            ST_S_RD:
            begin
                env_re = 1'b1;
                env_ra = jn[PW-1:0];
            end
            ST_S_WR:
            begin
                col_we  = !row_pass_reg;
                dist_we = row_pass_reg;
            end
            default: ;
        endcase
        env_we = push;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            width_reg     <= sat(CFG_W'(64), MAX_WIDTH);
            height_reg    <= sat(CFG_W'(64), MAX_HEIGHT);
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (cfg_we && cfg_addr == REG_IMAGE_WIDTH)
                width_reg <= sat(cfg_wdata, MAX_WIDTH);
            if (cfg_we && cfg_addr == REG_IMAGE_HEIGHT)
                height_reg <= sat(cfg_wdata, MAX_HEIGHT);
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        total_reg <= TW'(width_reg) * TW'(height_reg);
        prod_reg  <= PRW'(mul_a) * PRW'(mul_b);
        if (rsp_load)
            rsp_reg <= '{squared_distance: res_dist_reg, is_finite: res_fin_reg};
        if (push)
        begin
            top_v_reg <= xpos;
            top_f_reg <= push_f;
            top_z_reg <= s_val;
            cnt_reg   <= cnt_reg + LW'(1);
        end
        case (state_reg)
            ST_IDLE: if (cmd_valid) cmd_q_reg <= cmd;
            ST_EXEC:
            begin
                row_pass_reg <= 1'b0;
                line_reg     <= '0;
                base_reg     <= '0;
                any_reg      <= 1'b0;
            end
            ST_RD_WAIT:
            begin
                res_fin_reg  <= in_range && !dist_q[FW-1];
                res_dist_reg <= (in_range && !dist_q[FW-1]) ? DIST_W'(dist_q[DW-1:0]) : '0;
            end
            ST_LINE:
            begin
                cnt_reg     <= '0;
                q_reg       <= '0;
                addr_reg    <= base_reg;
                in_scan_reg <= 1'b0;
            end
            ST_B_CHK:
            begin
                qf_reg <= f_line[DW-1:0];
                if (!row_pass_reg && mask_q)
                    any_reg <= 1'b1;
                if (f_inf || cnt_reg == '0)
                begin
                    q_reg    <= q_reg + LW'(1);
                    addr_reg <= addr_reg + stride;
                end
            end
            ST_B_NUM: neg_reg <= num[NW-1];
            ST_B_DIV:
            begin
                if (div_done && !pop)
                begin
                    q_reg    <= q_reg + LW'(1);
                    addr_reg <= addr_reg + stride;
                end
            end
            ST_B_POP:
            begin
                top_v_reg <= env_pos_q;
                top_f_reg <= env_val_q;
                top_z_reg <= $signed(env_brk_q);
                cnt_reg   <= cnt_reg - LW'(1);
            end
            ST_S_INIT:
            begin
                j_reg       <= '0;
                q_reg       <= '0;
                addr_reg    <= base_reg;
                in_scan_reg <= 1'b1;
            end
            ST_S_LD:
            begin
                top_v_reg <= env_pos_q;
                top_f_reg <= env_val_q;
            end
            ST_S_CHK:
            begin
                if (advance)
                begin
                    j_reg     <= jn;
                    top_v_reg <= env_pos_q;
                    top_f_reg <= env_val_q;
                end
            end
            ST_S_WR:
            begin
                q_reg    <= q_reg + LW'(1);
                addr_reg <= addr_reg + stride;
                if (q_last)
                begin
                    if (!line_last)
                    begin
                        line_reg <= line_reg + LW'(1);
                        base_reg <= base_reg + base_step;
                    end
                    else if (!row_pass_reg)
                    begin
                        row_pass_reg <= 1'b1;
                        line_reg     <= '0;
                        base_reg     <= '0;
                    end
                    else
                    begin
                        res_dist_reg <= '0;
                        res_fin_reg  <= any_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    // Pixel memories
    always_ff @(posedge clk)
    begin
        if (mask_we)
            mask_mem[mask_wa] <= mask_wd;
        if (line_re)
            mask_q <= mask_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
            col_mem[addr_reg] <= wr_val;
        if (line_re)
            col_q <= col_mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[dist_wa] <= dist_wd;
        if (dist_re)
            dist_q <= dist_mem[AW'(cmd_q_reg.pixel_index)];
    end

    // Envelope stack of the current line
    always_ff @(posedge clk)
    begin
        if (env_we)
        begin
            env_pos_mem[cnt_reg[PW-1:0]] <= xpos;
            env_val_mem[cnt_reg[PW-1:0]] <= push_f;
            env_brk_mem[cnt_reg[PW-1:0]] <= s_val;
        end
        if (env_re)
        begin
            env_pos_q <= env_pos_mem[env_ra];
            env_val_q <= env_val_mem[env_ra];
            env_brk_q <= env_brk_mem[env_ra];
        end
    end

    // Shared crossing divider: |num| << FRAC_BITS over 2(q - p)
    sdt_div #(
        .DVD_W (QW),
        .DVS_W (PW + 1)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({mag, {FRAC_BITS{1'b0}}}),
        .divisor  ({diff, 1'b0}),
        .done     (div_done),
        .quotient (quo)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/sdt_check.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sdt_check (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input sdt_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp beat dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp))
        else $error("rsp payload changed while stalled");

    a_zero_when_inf: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.is_finite |-> rsp.squared_distance == '0)
        else $error("non-zero distance on a beat that is not finite");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("cmd taken while a beat is in progress");

endmodule

bind squared_euclidean_distance_transform sdt_check u_sdt_check (.*);

`default_nettype wire

// ----- sim/sdt_checker.sv -----
`timescale 1ns / 1ps

// Scoreboard for the distance transform: mirrors the register file and the
// pixel stores, predicts each rsp beat and compares it with what comes out.
module sdt_checker
    import sdt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             cmd_valid,
    input  logic             cmd_ready,
    input  cmd_t             cmd,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  rsp_t             rsp,
    output int               mismatches,
    output int               pending
);

    localparam int     LINE_MAX = 64;
    localparam int     PIX      = 4096;
    localparam longint NO_SRC   = -1;

    int     cur_width;
    int     cur_height;
    bit     mask_bits [PIX];
    longint column_dist [PIX];
    longint pixel_dist [PIX];
    longint line_f [LINE_MAX];
    longint line_d [LINE_MAX];
    rsp_t   expected_rsp [$];

    function automatic int clamp_size(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > LINE_MAX) ? LINE_MAX : int'(v);
    endfunction

    // Parabola crossing, fixed point with 16 fraction bits, cut toward zero.
    function automatic longint crossing(int p, int q);
        longint num;
        longint mag;
        longint val;
        num = line_f[q] + q * q - line_f[p] - p * p;
        mag = (num < 0) ? -num : num;
        val = (mag <<< 16) / (2 * (q - p));
        return (num < 0) ? -val : val;
    endfunction

    // Lower envelope of parabolas over line_f[0..n-1] into line_d.
    function automatic void envelope_line(int n);
        int     vertex [LINE_MAX];
        longint brk [LINE_MAX + 1];
        int     first;
        int     k;
        int     j;
        int     p;
        int     off;
        longint s;
        first = 0;
        k = 0;
        j = 0;
        while (first < n && line_f[first] == NO_SRC)
            first++;
        if (first >= n)
        begin
            for (int x = 0; x < n; x++)
                line_d[x] = NO_SRC;
            return;
        end
        vertex[0] = first;
        for (int q = first + 1; q < n; q++)
        begin
            if (line_f[q] == NO_SRC)
                continue;
            s = crossing(vertex[k], q);
            while (k > 0 && s <= brk[k])
            begin
                k--;
                s = crossing(vertex[k], q);
            end
            k++;
            vertex[k] = q;
            brk[k] = s;
        end
        for (int x = 0; x < n; x++)
        begin
            while (j < k && brk[j + 1] < (longint'(x) <<< 16))
                j++;
            p = vertex[j];
            off = (x > p) ? x - p : p - x;
            line_d[x] = off * off + line_f[p];
        end
    endfunction

    // Column pass then row pass; returns whether any source was seen.
    function automatic bit transform_image();
        bit found;
        found = 0;
        for (int c = 0; c < cur_width; c++)
        begin
            for (int r = 0; r < cur_height; r++)
            begin
                line_f[r] = mask_bits[r * cur_width + c] ? 0 : NO_SRC;
                if (mask_bits[r * cur_width + c])
                    found = 1;
            end
            envelope_line(cur_height);
            for (int r = 0; r < cur_height; r++)
                column_dist[r * cur_width + c] = line_d[r];
        end
        for (int r = 0; r < cur_height; r++)
        begin
            for (int c = 0; c < cur_width; c++)
                line_f[c] = column_dist[r * cur_width + c];
            envelope_line(cur_width);
            for (int c = 0; c < cur_width; c++)
                pixel_dist[r * cur_width + c] = line_d[c];
        end
        return found;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t got;
        int   total;
        if (!rst_n)
        begin
            cur_width = LINE_MAX;
            cur_height = LINE_MAX;
            for (int i = 0; i < PIX; i++)
            begin
                mask_bits[i] = 0;
                pixel_dist[i] = NO_SRC;
            end
            expected_rsp.delete();
            mismatches = 0;
        end
        else
        begin
            // Check the outgoing beat first so a same-edge command cannot mask it
            if (rsp_valid && rsp_ready)
            begin
                got = rsp;
                if (expected_rsp.size() == 0)
                    report_mismatch("unexpected rsp beat", got.squared_distance, -1);
                else
                begin
                    want = expected_rsp.pop_front();
                    if (got.squared_distance !== want.squared_distance)
                        report_mismatch("squared_distance", got.squared_distance,
                                        want.squared_distance);
                    if (got.is_finite !== want.is_finite)
                        report_mismatch("is_finite", got.is_finite, want.is_finite);
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                total = cur_width * cur_height;
                case (cmd.op)
                    OP_WRITE:
                        if (cmd.pixel_index < total)
                            mask_bits[cmd.pixel_index] = cmd.is_source;
                    OP_RUN:
                    begin
                        want.squared_distance = '0;
                        want.is_finite = transform_image();
                        expected_rsp.push_back(want);
                    end
                    OP_READ:
                    begin
                        if (cmd.pixel_index < total && pixel_dist[cmd.pixel_index] != NO_SRC)
                        begin
                            want.squared_distance = pixel_dist[cmd.pixel_index][DIST_W-1:0];
                            want.is_finite = 1'b1;
                        end
                        else
                            want = '0;
                        expected_rsp.push_back(want);
                    end
                    default: ;
                endcase
            end
            if (cfg_we)
            begin
                if (cfg_addr == REG_IMAGE_WIDTH)
                    cur_width = clamp_size(cfg_wdata);
                else
                    cur_height = clamp_size(cfg_wdata);
            end
        end
        pending = expected_rsp.size();
    end

endmodule

// ----- sim/tb_squared_euclidean_distance_transform.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the distance transform. Prediction and comparison
// live in sdt_checker; this module only drives the ports.
module tb_squared_euclidean_distance_transform;
    import sdt_pkg::*;

    localparam int  ITEM_TARGET = 1350;
    localparam int  CYCLE_LIMIT = 20_000_000;
    // A write may still be in flight once the last response is out
    localparam int  SETTLE      = 16;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic             cmd_valid;
    logic             cmd_ready;
    cmd_t             cmd;
    logic             rsp_valid;
    logic             rsp_ready;
    rsp_t             rsp;

    int mismatches;
    int pending;
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int cycle_count;
    int img_w;
    int img_h;

    squared_euclidean_distance_transform i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    sdt_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: the run must finish well inside this many cycles
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** squared_euclidean_distance_transform: FAILED **");
            $finish;
        end
    end

    // Receiver: a requested hold-off wins, otherwise stall at the phase rate
    initial
    begin
        rsp_ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one beat; keep valid high across back-to-back beats.
    task automatic send(logic [1:0] op, int idx, bit src);
        cmd_t beat;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        beat.op = op;
        beat.pixel_index = idx[IDX_W-1:0];
        beat.is_source = src;
        cmd_valid <= 1'b1;
        cmd <= beat;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drain the block, let any trailing write settle, then write a register.
    task automatic write_reg(logic addr, int value);
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(int w, int h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        img_w = w;
        img_h = h;
    endtask

    // One scene: pick a small image, paint a mask with random density, run,
    // then read back a spread of pixels. Some noise beats are mixed in.
    task automatic random_scene();
        int total;
        int density;
        int idx;
        int n;
        if ($urandom_range(9) == 0)
            set_geometry($urandom_range(16, 1), $urandom_range(16, 1));
        else
            set_geometry($urandom_range(8, 1), $urandom_range(8, 1));
        total = img_w * img_h;
        density = $urandom_range(100);
        n = $urandom_range(total + 2, 1);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(15) == 0)
                send(2'd3, $urandom_range(4095), $urandom_range(1));
            else if ($urandom_range(11) == 0)
                send(OP_WRITE, $urandom_range(4095), $urandom_range(1));
            else
            begin
                idx = $urandom_range(total - 1);
                send(OP_WRITE, idx, $urandom_range(99) < density);
            end
        end
        send(OP_RUN, $urandom_range(4095), $urandom_range(1));
        n = $urandom_range(20, 8);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                idx = $urandom_range(4095);
            else
                idx = $urandom_range(total - 1);
            send(OP_READ, idx, $urandom_range(1));
        end
    endtask

    initial
    begin
        int scene;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_IMAGE_WIDTH;
        cfg_wdata = '0;
        cmd_valid = 1'b0;
        cmd = '0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        cycle_count = 0;
        img_w = 64;
        img_h = 64;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Full-size image at reset geometry: read before any run, unused op,
        // sources at the two far corners, then reads across the frame.
        send(OP_READ, 0, 1'b0);
        send(2'd3, 4095, 1'b1);
        send(OP_WRITE, 0, 1'b1);
        send(OP_WRITE, 4095, 1'b1);
        send(OP_RUN, 0, 1'b0);
        send(OP_READ, 0, 1'b0);
        send(OP_READ, 4095, 1'b0);
        send(OP_READ, 63, 1'b0);
        send(OP_READ, 4032, 1'b0);
        send(OP_READ, 2080, 1'b1);

        // Saturating register writes: zero clamps to one, 127 to the maximum
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 127);
        img_w = 1;
        img_h = 64;
        send(OP_RUN, 0, 1'b0);
        send(OP_READ, 63, 1'b0);
        send(OP_READ, 64, 1'b0);

        // Single row with the only source cleared: run reports no source
        set_geometry(64, 1);
        send(OP_WRITE, 0, 1'b0);
        send(OP_WRITE, 64, 1'b1);
        send(OP_RUN, 0, 1'b0);
        send(OP_READ, 5, 1'b0);
        send(OP_READ, 63, 1'b0);

        // Back-pressure: hold the receiver off while reads pile up
        set_geometry(4, 4);
        send(OP_WRITE, 5, 1'b1);
        send(OP_RUN, 0, 1'b0);
        hold_off_cycles = 400;
        for (int i = 0; i < 24; i++)
            send(OP_READ, i, 1'b0);

        // Random scenes, cycling through the idling phases
        scene = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (scene % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            random_scene();
            // After scene 7, pause the sender until the block has answered everything
            if (scene == 7)
            begin
                cmd_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            scene++;
        end

        cmd_valid <= 1'b0;
        recv_stall_pct = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("** squared_euclidean_distance_transform: PASSED **");
        else
            $display("** squared_euclidean_distance_transform: FAILED **");
        $finish;
    end

endmodule
